@@ hdl/bchc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchc_pkg
// Types and constants shared by the button click / hold classifier.
// ----------------------------------------------------------------------------
package bchc_pkg;

    localparam int unsigned TimeW    = 32;
    localparam int unsigned CfgW     = 16;
    localparam int unsigned CountW   = 8;
    localparam int unsigned CfgAddrW = 3;
    localparam int unsigned InDataW  = 40;
    localparam int unsigned OutDataW = 8;

    localparam logic [CountW-1:0] CountMax = 8'd255;

    // Register indexes on the configuration port
    localparam logic [CfgAddrW-1:0] RegDebounce  = 3'd0;
    localparam logic [CfgAddrW-1:0] RegHold      = 3'd1;
    localparam logic [CfgAddrW-1:0] RegMaxHold   = 3'd2;
    localparam logic [CfgAddrW-1:0] RegClickWin  = 3'd3;
    localparam logic [CfgAddrW-1:0] RegPairCount = 3'd4;

    localparam logic [CfgW-1:0]   DebounceRst  = 16'd50;
    localparam logic [CfgW-1:0]   HoldRst      = 16'd600;
    localparam logic [CfgW-1:0]   MaxHoldRst   = 16'd30000;
    localparam logic [CfgW-1:0]   ClickWinRst  = 16'd400;
    localparam logic [CountW-1:0] PairCountRst = 8'd5;

    typedef enum logic [3:0] {
        EV_NONE             = 4'd0,
        EV_CLICK            = 4'd1,
        EV_DOUBLE           = 4'd2,
        EV_TRIPLE           = 4'd3,
        EV_PAIRING          = 4'd4,
        EV_HOLD_START       = 4'd5,
        EV_HOLD_END         = 4'd6,
        EV_CLICK_HOLD_START = 4'd7,
        EV_CLICK_HOLD_END   = 4'd8
    } event_t;

    typedef enum logic [3:0] {
        MODE_IDLE          = 4'b0001,
        MODE_HOLDING       = 4'b0010,
        MODE_CLICK_HOLDING = 4'b0100,
        MODE_STUCK         = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [CfgW-1:0]   debounce_time;
        logic [CfgW-1:0]   hold_time;
        logic [CfgW-1:0]   max_hold_time;
        logic [CfgW-1:0]   click_window;
        logic [CountW-1:0] pairing_click_count;
    } cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic [TimeW-1:0]   press_time;
        logic               press_valid;
        logic [TimeW-1:0]   release_time;
        logic               release_valid;
        logic [CountW-1:0]  click_count;
    } state_t;

endpackage
`default_nettype wire

@@ hdl/bchc_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bchc_step
// Next-state and event logic for one button sample.
// ----------------------------------------------------------------------------
module bchc_step (
    input  wire bchc_pkg::cfg_t               cfg,
    input  wire bchc_pkg::state_t             cur,
    input  wire                               pressed,
    input  wire [bchc_pkg::TimeW-1:0]         now_ms,
    output bchc_pkg::state_t                  nxt,
    output bchc_pkg::event_t                  event_code
);
    import bchc_pkg::*;

    logic [TimeW-1:0] press_base;
    logic [TimeW-1:0] press_dt;
    logic [TimeW-1:0] release_dt;
    logic [TimeW-1:0] debounce_x;
    logic [TimeW-1:0] hold_x;
    logic [TimeW-1:0] max_hold_x;
    logic [TimeW-1:0] window_x;

    assign press_base = cur.press_valid ? cur.press_time : now_ms;
    assign press_dt   = now_ms - press_base;
    assign release_dt = now_ms - cur.release_time;
    assign debounce_x = {{(TimeW-CfgW){1'b0}}, cfg.debounce_time};
    assign hold_x     = {{(TimeW-CfgW){1'b0}}, cfg.hold_time};
    assign max_hold_x = {{(TimeW-CfgW){1'b0}}, cfg.max_hold_time};
    assign window_x   = {{(TimeW-CfgW){1'b0}}, cfg.click_window};

    always_comb begin
        nxt        = cur;
        event_code = EV_NONE;
        if (pressed) begin
            nxt.release_valid = 1'b0;
            if (cur.mode != MODE_STUCK) begin
                nxt.press_time  = press_base;
                nxt.press_valid = 1'b1;
                if (press_dt < debounce_x) begin
                    event_code = EV_NONE;
                end else if (press_dt >= hold_x && press_dt < max_hold_x) begin
                    if (cur.mode == MODE_IDLE) begin
                        if (cur.click_count == '0) begin
                            nxt.mode   = MODE_HOLDING;
                            event_code = EV_HOLD_START;
                        end else begin
                            nxt.mode   = MODE_CLICK_HOLDING;
                            event_code = EV_CLICK_HOLD_START;
                        end
                    end
                end else if (press_dt >= max_hold_x) begin
                    if (cur.mode == MODE_HOLDING) begin
                        event_code = EV_HOLD_END;
                    end else if (cur.mode == MODE_CLICK_HOLDING) begin
                        event_code = EV_CLICK_HOLD_END;
                    end
                    nxt.mode        = MODE_STUCK;
                    nxt.press_valid = 1'b0;
                    nxt.press_time  = '0;
                    nxt.click_count = '0;
                end
            end
        end else if (cur.press_valid) begin
            nxt.press_valid = 1'b0;
            nxt.press_time  = '0;
            if (press_dt >= debounce_x) begin
                if (cur.mode == MODE_HOLDING) begin
                    nxt.mode        = MODE_IDLE;
                    nxt.click_count = '0;
                    event_code      = EV_HOLD_END;
                end else if (cur.mode == MODE_CLICK_HOLDING) begin
                    nxt.mode        = MODE_IDLE;
                    nxt.click_count = '0;
                    event_code      = EV_CLICK_HOLD_END;
                end else begin
                    if (cur.click_count != CountMax) begin
                        nxt.click_count = cur.click_count + 1'b1;
                    end
                    if (!cur.release_valid) begin
                        nxt.release_time  = now_ms;
                        nxt.release_valid = 1'b1;
                    end
                end
            end
        end else if (cur.mode == MODE_STUCK) begin
            nxt.mode          = MODE_IDLE;
            nxt.release_valid = 1'b0;
            nxt.click_count   = '0;
        end else if (cur.release_valid) begin
            // Window expired: close the click sequence
            if (release_dt >= debounce_x && release_dt >= window_x) begin
                priority if (cur.click_count == 8'd1) begin
                    event_code = EV_CLICK;
                end else if (cur.click_count == 8'd2) begin
                    event_code = EV_DOUBLE;
                end else if (cur.click_count >= 8'd3 &&
                             cur.click_count < cfg.pairing_click_count) begin
                    event_code = EV_TRIPLE;
                end else begin
                    event_code = EV_PAIRING;
                end
                nxt.click_count   = '0;
                nxt.release_valid = 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/button_click_hold_classifier.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Path: input register, then bchc_step logic, then result register onto m_tdata.
// Throughput: one sample per cycle unless m_tready stalls; the state update is one
//   pass of subtract/compare logic between the input and result registers.
// Reset (aresetn low, synchronous): configuration returns to its defaults,
//   mode to idle, both timestamps unset, click count zero, both stages empty.
// ----------------------------------------------------------------------------
// button_click_hold_classifier
// Classifies button samples into click, multi-click, pairing and hold events.
// ----------------------------------------------------------------------------
module button_click_hold_classifier (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire [bchc_pkg::CfgAddrW-1:0]       cfg_addr,
    input  wire [bchc_pkg::CfgW-1:0]           cfg_wdata,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // [0] pressed, [32:1] now_ms, [39:33] zero
    input  wire [bchc_pkg::InDataW-1:0]        s_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // [3:0] event_code, [7:4] zero
    output logic [bchc_pkg::OutDataW-1:0]      m_tdata
);
    import bchc_pkg::*;

    cfg_t              cfg_reg;
    state_t            state_reg;
    state_t            state_next;
    event_t            event_next;
    logic              in_valid_reg;
    logic              in_pressed_reg;
    logic [TimeW-1:0]  in_now_reg;
    logic              out_valid_reg;
    event_t            out_event_reg;
    logic              advance;
    logic              fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW-4){1'b0}}, out_event_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_time       <= DebounceRst;
            cfg_reg.hold_time           <= HoldRst;
            cfg_reg.max_hold_time       <= MaxHoldRst;
            cfg_reg.click_window        <= ClickWinRst;
            cfg_reg.pairing_click_count <= PairCountRst;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                RegDebounce:  cfg_reg.debounce_time       <= cfg_wdata;
                RegHold:      cfg_reg.hold_time           <= cfg_wdata;
                RegMaxHold:   cfg_reg.max_hold_time       <= cfg_wdata;
                RegClickWin:  cfg_reg.click_window        <= cfg_wdata;
                RegPairCount: cfg_reg.pairing_click_count <= cfg_wdata[CountW-1:0];
                default: ;
            endcase
        end
    end

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_pressed_reg <= s_tdata[0];
            in_now_reg     <= s_tdata[TimeW:1];
        end
    end

    bchc_step u_step (
        .cfg        (cfg_reg),
        .cur        (state_reg),
        .pressed    (in_pressed_reg),
        .now_ms     (in_now_reg),
        .nxt        (state_next),
        .event_code (event_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode          <= MODE_IDLE;
            state_reg.press_time    <= '0;
            state_reg.press_valid   <= 1'b0;
            state_reg.release_time  <= '0;
            state_reg.release_valid <= 1'b0;
            state_reg.click_count   <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_event_reg <= event_next;
        end
    end

    // A stuck button never keeps a press timestamp
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.mode == MODE_STUCK |-> !state_reg.press_valid)
        else $error("stuck mode with a live press time");

    // A plain hold only starts with no clicks counted
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.mode == MODE_HOLDING |-> state_reg.click_count == '0)
        else $error("holding mode with clicks pending");

    // State moves only when a sample passes into the result stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(state_reg))
        else $error("state changed without a sample");

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button click / hold classifier. A short table
// of samples walks clicks, short releases, holds, a stuck button across the
// timestamp wrap, a click-hold and a triple click. Random button gestures then
// run under several register settings, extremes included, and a burst long
// enough to saturate the click count. Every sample yields one event, checked in
// order against the row's event where one is given, else a cycle-free model.
// ----------------------------------------------------------------------------
module tb_top;
    import bchc_pkg::*;

    localparam int CycleLimit = 600000;

    typedef struct packed {
        logic        pressed;
        logic [31:0] now;
        logic        typed;
        event_t      ev;
    } sample_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CfgAddrW-1:0] cfg_addr = '0;
    logic [CfgW-1:0]     cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;

    // Model copy of the registers
    logic [CfgW-1:0]   cfg_debounce  = DebounceRst;
    logic [CfgW-1:0]   cfg_hold      = HoldRst;
    logic [CfgW-1:0]   cfg_max_hold  = MaxHoldRst;
    logic [CfgW-1:0]   cfg_click_win = ClickWinRst;
    logic [CountW-1:0] cfg_pair      = PairCountRst;

    // Model copy of the button state
    mode_t             btn_mode   = MODE_IDLE;
    logic [TimeW-1:0]  press_ts   = '0;
    logic              press_set  = 1'b0;
    logic [TimeW-1:0]  release_ts = '0;
    logic              release_set = 1'b0;
    logic [CountW-1:0] clicks     = '0;

    event_t      pending_events[$];
    int          err_count = 0;
    int          cycle_count = 0;
    int          results_seen = 0;
    int          rx_seen_last = 0;
    int          rx_stall_left = 0;
    int          rx_run_left = 0;
    int          tx_run_left = 0;
    int          sent_items = 0;
    logic [31:0] wall_ms = 32'd1000;
    logic        row_typed = 1'b0;
    event_t      row_event = EV_NONE;

    sample_row_t sample_rows [0:24] = '{
        '{1'b0, 32'd0,         1'b1, EV_NONE},
        '{1'b1, 32'd0,         1'b1, EV_NONE},
        '{1'b0, 32'd100,       1'b1, EV_NONE},
        '{1'b0, 32'd500,       1'b1, EV_CLICK},
        // release inside the debounce time is dropped
        '{1'b1, 32'd2000,      1'b1, EV_NONE},
        '{1'b0, 32'd2049,      1'b1, EV_NONE},
        '{1'b1, 32'd4000,      1'b1, EV_NONE},
        '{1'b1, 32'd4600,      1'b1, EV_HOLD_START},
        '{1'b0, 32'd5100,      1'b1, EV_HOLD_END},
        // hold across the timestamp wrap until the button is stuck
        '{1'b1, 32'hFFFF_FFF0, 1'b1, EV_NONE},
        '{1'b1, 32'h0000_0248, 1'b1, EV_HOLD_START},
        '{1'b1, 32'h0000_7520, 1'b1, EV_HOLD_END},
        '{1'b0, 32'h0000_8000, 1'b1, EV_NONE},
        '{1'b1, 32'd50000,     1'b0, EV_NONE},
        '{1'b0, 32'd50100,     1'b0, EV_NONE},
        '{1'b1, 32'd50200,     1'b0, EV_NONE},
        '{1'b1, 32'd50800,     1'b1, EV_CLICK_HOLD_START},
        '{1'b0, 32'd50900,     1'b1, EV_CLICK_HOLD_END},
        '{1'b1, 32'd60000,     1'b0, EV_NONE},
        '{1'b0, 32'd60060,     1'b0, EV_NONE},
        '{1'b1, 32'd60100,     1'b0, EV_NONE},
        '{1'b0, 32'd60160,     1'b0, EV_NONE},
        '{1'b1, 32'd60200,     1'b0, EV_NONE},
        '{1'b0, 32'd60260,     1'b0, EV_NONE},
        '{1'b0, 32'd60660,     1'b1, EV_TRIPLE}
    };

    button_click_hold_classifier u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Advance the button state by one sample and return the event it raises
    function automatic event_t classify_sample(input logic pressed, input logic [31:0] now);
        logic [31:0] d;
        event_t      ev;
        ev = EV_NONE;
        if (pressed) begin
            release_set = 1'b0;
            if (btn_mode != MODE_STUCK) begin
                if (!press_set) begin
                    press_ts  = now;
                    press_set = 1'b1;
                end
                d = now - press_ts;
                if (d >= cfg_debounce) begin
                    if (d >= cfg_hold && d < cfg_max_hold) begin
                        if (btn_mode == MODE_IDLE) begin
                            if (clicks == 0) begin
                                btn_mode = MODE_HOLDING;
                                ev = EV_HOLD_START;
                            end else begin
                                btn_mode = MODE_CLICK_HOLDING;
                                ev = EV_CLICK_HOLD_START;
                            end
                        end
                    end else if (d >= cfg_max_hold) begin
                        if (btn_mode == MODE_HOLDING) ev = EV_HOLD_END;
                        else if (btn_mode == MODE_CLICK_HOLDING) ev = EV_CLICK_HOLD_END;
                        btn_mode  = MODE_STUCK;
                        press_set = 1'b0;
                        press_ts  = '0;
                        clicks    = '0;
                    end
                end
            end
        end else if (press_set) begin
            d = now - press_ts;
            press_set = 1'b0;
            press_ts  = '0;
            if (d >= cfg_debounce) begin
                if (btn_mode == MODE_HOLDING) begin
                    btn_mode = MODE_IDLE;
                    clicks   = '0;
                    ev = EV_HOLD_END;
                end else if (btn_mode == MODE_CLICK_HOLDING) begin
                    btn_mode = MODE_IDLE;
                    clicks   = '0;
                    ev = EV_CLICK_HOLD_END;
                end else begin
                    if (clicks != CountMax) clicks = clicks + 1'b1;
                    if (!release_set) begin
                        release_ts  = now;
                        release_set = 1'b1;
                    end
                end
            end
        end else if (btn_mode == MODE_STUCK) begin
            btn_mode    = MODE_IDLE;
            release_set = 1'b0;
            clicks      = '0;
        end else if (release_set) begin
            d = now - release_ts;
            // close the click sequence once the window has run out
            if (d >= cfg_debounce && d >= cfg_click_win) begin
                if (clicks == 1) ev = EV_CLICK;
                else if (clicks == 2) ev = EV_DOUBLE;
                else if (clicks >= 3 && clicks < cfg_pair) ev = EV_TRIPLE;
                else ev = EV_PAIRING;
                clicks      = '0;
                release_set = 1'b0;
            end
        end
        return ev;
    endfunction

    // Cycles to wait before the next transfer, with runs of back-to-back ones
    function automatic int draw_wait(inout int run_left);
        int w;
        if (run_left > 0) begin
            run_left = run_left - 1;
            w = 0;
        end else begin
            w = int'($urandom_range(0, 9));
            if ($urandom_range(0, 29) == 0) run_left = int'($urandom_range(10, 40));
        end
        return w;
    endfunction

    // Interval near a threshold, on either side of it
    function automatic logic [31:0] around(input logic [31:0] thr);
        logic [31:0] r;
        case ($urandom_range(0, 5))
            0: r = (thr == 0) ? 32'd0 : thr - 1;
            1: r = thr;
            2: r = thr + 1;
            3: r = $urandom_range(0, thr);
            4: r = thr + $urandom_range(0, 64);
            default: r = $urandom_range(0, 2 * thr + 1);
        endcase
        return r;
    endfunction

    function automatic logic [31:0] click_len();
        logic [31:0] r;
        if (cfg_hold > cfg_debounce) r = $urandom_range(cfg_debounce, cfg_hold - 1);
        else r = around(cfg_debounce);
        return r;
    endfunction

    function automatic logic [31:0] seq_end_gap();
        logic [31:0] top;
        top = (cfg_debounce > cfg_click_win) ? cfg_debounce : cfg_click_win;
        return ($urandom_range(0, 3) == 0) ? around(top) : top + $urandom_range(0, 50);
    endfunction

    // Receiver: stall a drawn number of cycles after every result transfer
    always @(negedge aclk) begin
        if (results_seen != rx_seen_last) begin
            rx_seen_last  = results_seen;
            rx_stall_left = draw_wait(rx_run_left);
        end
        if (rx_stall_left == 0) begin
            m_tready = 1'b1;
        end else begin
            m_tready = 1'b0;
            rx_stall_left = rx_stall_left - 1;
        end
    end

    always @(posedge aclk) begin : monitor
        event_t want;
        event_t pred;
        if (aresetn) begin
            // check the result before queueing this edge's sample
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (pending_events.size() == 0) begin
                    err_count = err_count + 1;
                    if (err_count <= 10)
                        $display("[%0t] unexpected event %0d", $realtime, m_tdata[3:0]);
                end else begin
                    want = pending_events.pop_front();
                    if (m_tdata[3:0] !== want) begin
                        err_count = err_count + 1;
                        if (err_count <= 10)
                            $display("[%0t] event_code mismatch: expected %0d, got %0d",
                                     $realtime, want, m_tdata[3:0]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pred = classify_sample(s_tdata[0], s_tdata[32:1]);
                pending_events.push_back(row_typed ? row_event : pred);
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    RegDebounce:  cfg_debounce  = cfg_wdata;
                    RegHold:      cfg_hold      = cfg_wdata;
                    RegMaxHold:   cfg_max_hold  = cfg_wdata;
                    RegClickWin:  cfg_click_win = cfg_wdata;
                    RegPairCount: cfg_pair      = cfg_wdata[CountW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Call just after a falling edge; returns just after a falling edge
    task automatic send(input logic pressed, input logic [31:0] now,
                        input logic typed, input event_t ev);
        int gap;
        gap = draw_wait(tx_run_left);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata   = {7'd0, now, pressed};
        row_typed = typed;
        row_event = ev;
        s_tvalid  = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        sent_items++;
    endtask

    task automatic sample(input logic pressed, input logic [31:0] step);
        wall_ms = wall_ms + step;
        send(pressed, wall_ms, 1'b0, EV_NONE);
    endtask

    task automatic press_release(input logic [31:0] lead, input logic [31:0] len);
        sample(1'b1, lead);
        if ($urandom_range(0, 2) == 0) begin
            sample(1'b1, len / 2);
            sample(1'b0, len - len / 2);
        end else begin
            sample(1'b0, len);
        end
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_events.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apply_config(input logic [15:0] deb, input logic [15:0] hold,
                                input logic [15:0] max_hold, input logic [15:0] win,
                                input logic [7:0] pair);
        drain();
        cfg_wr_en = 1'b1;
        cfg_addr = RegDebounce;  cfg_wdata = deb;         @(negedge aclk);
        cfg_addr = RegHold;      cfg_wdata = hold;        @(negedge aclk);
        cfg_addr = RegMaxHold;   cfg_wdata = max_hold;    @(negedge aclk);
        cfg_addr = RegClickWin;  cfg_wdata = win;         @(negedge aclk);
        cfg_addr = RegPairCount; cfg_wdata = {8'd0, pair}; @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic gesture();
        int kind;
        int n;
        kind = int'($urandom_range(0, 19));
        if (kind < 8) begin
            // click run, sometimes long enough for pairing
            n = ($urandom_range(0, 3) == 0) ?
                int'($urandom_range(1, (cfg_pair < 8) ? int'(cfg_pair) + 1 : 9)) :
                int'($urandom_range(1, 3));
            repeat (n) press_release($urandom_range(0, cfg_click_win), click_len());
            sample(1'b0, seq_end_gap());
        end else if (kind < 11) begin
            // hold, plain or after a few clicks, possibly into stuck
            n = int'($urandom_range(0, 2));
            repeat (n) press_release($urandom_range(0, cfg_click_win), click_len());
            sample(1'b1, $urandom_range(0, cfg_click_win));
            sample(1'b1, around(cfg_hold));
            if ($urandom_range(0, 1)) sample(1'b1, around(cfg_max_hold - cfg_hold));
            sample(1'b1, $urandom_range(0, 200));
            sample(1'b0, $urandom_range(0, 2 * cfg_debounce + 1));
            sample(1'b0, seq_end_gap());
        end else if (kind < 13) begin
            press_release($urandom_range(0, cfg_click_win), around(cfg_debounce));
        end else if (kind < 16) begin
            sample(1'b0, around(cfg_click_win));
        end else begin
            if ($urandom_range(0, 1)) wall_ms = $urandom;
            sample(1'($urandom_range(0, 1)), $urandom_range(0, 70000));
        end
    endtask

    task automatic run_gestures(input int count);
        int first;
        first = sent_items;
        while (sent_items - first < count) gesture();
    endtask

    initial begin : stimulus
        logic [15:0] h;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (sample_rows[i])
            send(sample_rows[i].pressed, sample_rows[i].now, sample_rows[i].typed,
                 sample_rows[i].ev);

        apply_config(16'($urandom_range(0, 200)), 16'd900, 16'd6000,
                     16'($urandom_range(0, 800)), 8'($urandom_range(4, 8)));
        run_gestures(300);

        apply_config(16'd0, 16'd0, 16'd0, 16'd0, 8'd4);
        run_gestures(150);

        // all registers at the top: the hold window is empty
        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
        run_gestures(120);

        // saturate the click count, then close the sequence
        apply_config(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
        repeat (260) press_release($urandom_range(0, 1000), $urandom_range(0, 1000));
        sample(1'b0, 32'd65535 + $urandom_range(0, 10));
        run_gestures(100);

        h = 16'($urandom_range(1000, 5000));
        apply_config(16'($urandom_range(0, 100)), h, 16'($urandom_range(0, h)),
                     16'($urandom_range(0, 600)), 8'($urandom_range(4, 255)));
        run_gestures(230);

        drain();
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/bchc_pkg.sv
hdl/bchc_step.sv
hdl/button_click_hold_classifier.sv
sim/tb_top.sv
